/* rtl/playfair_digraph_encryptor_defines.svh */
// ----------------------------------------------------------------------------
// Playfair digraph encryptor assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked during reset as well
`define PFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PFE_ASSERT(lbl, prop, msg)
`define PFE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// Playfair digraph encryptor package
// Shared types, letter codes and register map of the encryptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned NUM_ROWS = 5;
  localparam int unsigned NUM_COLS = 5;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [2:0]          idx_t;

  // column k at bits 5k
  typedef logic [NUM_COLS-1:0][LETTER_W-1:0] row_t;
  typedef row_t [NUM_ROWS-1:0]               rows_t;

  localparam letter_t LETTER_X = letter_t'(23);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_I = letter_t'(8);

  // alphabet without J, row-major
  localparam rows_t ROWS_RESET = '{
    row_t'(25'd27025109),
    row_t'(25'd21613104),
    row_t'(25'd16201099),
    row_t'(25'd10755269),
    row_t'(25'd4294688)
  };

  typedef enum logic [2:0] {
    REG_ROW_0 = 3'd0,
    REG_ROW_1 = 3'd1,
    REG_ROW_2 = 3'd2,
    REG_ROW_3 = 3'd3,
    REG_ROW_4 = 3'd4
  } reg_idx_e;

  // one or two cipher digraphs waiting for the output
  typedef struct packed {
    letter_t e1;
    letter_t e2;
    logic    quad;
  } result_t;

  function automatic idx_t inc_wrap(idx_t i);
    return (i == idx_t'(NUM_COLS - 1)) ? '0 : i + 3'd1;
  endfunction

endpackage

/* rtl/playfair_digraph_encryptor.sv */
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Pairs plaintext letters into digraphs and encrypts them with a 5x5 square.
// ----------------------------------------------------------------------------
// Plaintext letters enter on the s_axis channel, one word per letter, with
// tlast marking the final letter of a message. Cipher letters leave on the
// m_axis channel, with tlast on the final word caused by each input letter.
// A letter yields no word while it waits for its partner, two words for one
// digraph, or four when a doubled final letter forces two X-padded pairs.
// The key square lives in five APB registers (row i at byte 4*i); the user
// must write it only while the stream is idle; the block does not enforce this.
// A letter is registered in the input register on entry; once the result
// buffer is free it is paired and encrypted combinationally and its cipher
// words are loaded into the result buffer, which drives m_axis.
// The result buffer sends one output word a cycle while the receiver is
// ready, and takes the next digraph as its last word is accepted.
// Reset loads the alphabet without J into the square and drops any waiting
// letter. When the receiver stalls, the result buffer holds its word and
// the input register fills, after which s_axis_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "playfair_digraph_encryptor_defines.svh"

module playfair_digraph_encryptor import pfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] unused
  input  logic        s_axis_tlast,   // last_letter
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
  output logic        m_axis_tlast    // end_of_run
);

  rows_t   rows;
  logic    in_v_q, in_v_d;
  letter_t in_letter_q;
  logic    in_last_q;
  logic    held_v_q, held_v_d;
  letter_t held_q, held_d;
  logic    buf_free, adv, s_accept, emit, load;
  letter_t a, pa, pb;
  letter_t res_e1, res_e2;
  logic    res_quad;
  result_t res;

  pfe_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (rows)
  );

  assign adv           = in_v_q & buf_free;
  assign s_axis_tready = ~in_v_q | buf_free;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (s_accept) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      held_v_q <= 1'b0;
      held_q   <= '0;
    end else begin
      in_v_q   <= in_v_d;
      held_v_q <= held_v_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_letter_q <= s_axis_tdata[4:0];
      in_last_q   <= s_axis_tlast;
    end
  end

  assign a = (in_letter_q == LETTER_J) ? LETTER_I : in_letter_q;

  // a doubled final letter repeats the same (letter, X) pair twice
  always_comb begin
    pa       = a;
    pb       = LETTER_X;
    emit     = 1'b0;
    res_quad = 1'b0;
    held_v_d = held_v_q;
    held_d   = held_q;
    if (adv) begin
      if (!held_v_q) begin
        if (in_last_q) begin
          emit = 1'b1;
        end else begin
          held_v_d = 1'b1;
          held_d   = a;
        end
      end else if (held_q != a) begin
        pa       = held_q;
        pb       = a;
        emit     = 1'b1;
        held_v_d = 1'b0;
        held_d   = '0;
      end else begin
        emit = 1'b1;
        if (in_last_q) begin
          res_quad = 1'b1;
          held_v_d = 1'b0;
          held_d   = '0;
        end
      end
    end
  end

  pfe_pair_cipher u_cipher (
    .rows_i (rows),
    .a_i    (pa),
    .b_i    (pb),
    .e1_o   (res_e1),
    .e2_o   (res_e2)
  );

  assign res  = '{e1: res_e1, e2: res_e2, quad: res_quad};
  assign load = adv & emit;

  pfe_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `PFE_ASSERT(a_lone_held, (adv && !held_v_q && !in_last_q) |=> held_v_q,
              "unpaired letter not held")
  `PFE_ASSERT(a_last_clears, (adv && in_last_q) |=> !held_v_q,
              "letter still held after end of message")
  `PFE_ASSERT(a_held_waits, (adv && !held_v_q && !in_last_q) |-> !load,
              "output produced for a waiting letter")

endmodule

/* rtl/pfe_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Table row registers
// APB-style register file holding the five rows of the key square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_cfg_regs import pfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rows_t       rows_o
);

  rows_t    rows_q, rows_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    rows_d = rows_q;
    if (wr_en) begin
      case (idx)
        REG_ROW_0: rows_d[0] = row_t'(pwdata[24:0]);
        REG_ROW_1: rows_d[1] = row_t'(pwdata[24:0]);
        REG_ROW_2: rows_d[2] = row_t'(pwdata[24:0]);
        REG_ROW_3: rows_d[3] = row_t'(pwdata[24:0]);
        REG_ROW_4: rows_d[4] = row_t'(pwdata[24:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_0: prdata = {7'd0, rows_q[0]};
      REG_ROW_1: prdata = {7'd0, rows_q[1]};
      REG_ROW_2: prdata = {7'd0, rows_q[2]};
      REG_ROW_3: prdata = {7'd0, rows_q[3]};
      REG_ROW_4: prdata = {7'd0, rows_q[4]};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
    end else begin
      rows_q <= rows_d;
    end
  end

  assign rows_o = rows_q;

endmodule

/* rtl/pfe_pair_cipher.sv */
// ----------------------------------------------------------------------------
// Digraph cipher
// Locates both letters in the key square and applies the Playfair rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_pair_cipher import pfe_pkg::*; (
  input  rows_t   rows_i,
  input  letter_t a_i,
  input  letter_t b_i,
  output letter_t e1_o,
  output letter_t e2_o
);

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  // last match in row-major order wins, no match gives the top-left corner
  function automatic pos_t locate(rows_t rows, letter_t v);
    pos_t p;
    p = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (rows[r][c] == v) begin
          p.row = idx_t'(r);
          p.col = idx_t'(c);
        end
      end
    end
    return p;
  endfunction

  pos_t p1, p2;

  assign p1 = locate(rows_i, a_i);
  assign p2 = locate(rows_i, b_i);

  always_comb begin
    if (p1.row == p2.row) begin
      e1_o = rows_i[p1.row][inc_wrap(p1.col)];
      e2_o = rows_i[p2.row][inc_wrap(p2.col)];
    end else if (p1.col == p2.col) begin
      e1_o = rows_i[inc_wrap(p1.row)][p1.col];
      e2_o = rows_i[inc_wrap(p2.row)][p2.col];
    end else begin
      e1_o = rows_i[p1.row][p2.col];
      e2_o = rows_i[p2.row][p1.col];
    end
  end

endmodule

/* rtl/pfe_out_buf.sv */
// ----------------------------------------------------------------------------
// Result buffer
// Holds one cipher digraph, sent once or twice, and streams it out a word a
// cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "playfair_digraph_encryptor_defines.svh"

module pfe_out_buf import pfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  output logic       free_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
  output logic       m_axis_tlast    // end_of_run
);

  result_t    res_q;
  logic [2:0] rem_q, rem_d;

  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tlast  = (rem_q == 3'd1);
  // even count left: first letter of the digraph
  assign m_axis_tdata  = {3'd0, rem_q[0] ? res_q.e2 : res_q.e1};
  assign free_o        = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);

  always_comb begin
    rem_d = rem_q;
    if (m_axis_tvalid && m_axis_tready) begin
      rem_d = rem_q - 3'd1;
    end
    if (load_i) begin
      rem_d = res_i.quad ? 3'd4 : 3'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  `PFE_ASSERT_RST(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `PFE_ASSERT(a_stall_holds, (m_axis_tvalid && !m_axis_tready) |=> $stable(rem_q),
              "word count moved while stalled")
  `PFE_ASSERT(a_drain_empty, (m_axis_tvalid && m_axis_tready && m_axis_tlast && !load_i)
              |=> !m_axis_tvalid, "buffer not empty after last word")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Playfair digraph encryptor testbench
// Sends plaintext letters through the encryptor under random flow control on
// both streams and checks every cipher word against a digraph predictor that
// keeps its own copy of the key square and of the waiting letter. A short
// directed table, run on the reset square, comes first. Random messages
// follow under several squares loaded over APB: shuffled alphabets, all-zero
// and all-ones rows, and random rows with repeated letters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pfe_pkg::*;

  localparam int          ITEMS_PER_PHASE = 40;
  localparam int          NUM_PHASES      = 6;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          LONG_HOLD       = 150;
  localparam int          QUIET_LIMIT     = 2000;
  localparam logic [2:0]  UNCHECKED       = 3'd7;

  typedef struct packed {
    letter_t ltr;
    logic    eor;
  } cipher_word_t;

  // e0..e3 are typed cipher letters; the last one carries end_of_run
  typedef struct packed {
    letter_t    ltr;
    logic       last;
    logic [2:0] cnt;
    letter_t    e0;
    letter_t    e1;
    letter_t    e2;
    letter_t    e3;
  } dir_row_t;

  // reset square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
  localparam dir_row_t DIRECTED [25] = '{
    '{5'd0,  1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd4,  1'b0, 3'd2,      5'd1,  5'd0,  5'd0, 5'd0},   // same row, wraps
    '{5'd0,  1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd21, 1'b0, 3'd2,      5'd5,  5'd0,  5'd0, 5'd0},   // same column, wraps
    '{5'd25, 1'b1, 3'd2,      5'd21, 5'd24, 5'd0, 5'd0},   // lone last, X padding
    '{5'd9,  1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},   // J taken as I
    '{5'd8,  1'b0, 3'd2,      5'd7,  5'd24, 5'd0, 5'd0},   // doubled letter
    '{5'd8,  1'b1, 3'd4,      5'd7,  5'd24, 5'd7, 5'd24},  // doubled final letter
    '{5'd23, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd23, 1'b0, 3'd2,      5'd24, 5'd24, 5'd0, 5'd0},   // double X
    '{5'd23, 1'b1, 3'd4,      5'd24, 5'd24, 5'd24, 5'd24},
    '{5'd31, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},   // codes off the square
    '{5'd26, 1'b0, 3'd2,      5'd1,  5'd1,  5'd0, 5'd0},
    '{5'd27, 1'b1, 3'd2,      5'd2,  5'd21, 5'd0, 5'd0},
    '{5'd12, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd25, 1'b0, UNCHECKED, 5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd10, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd28, 1'b1, UNCHECKED, 5'd0,  5'd0,  5'd0, 5'd0},   // last completes a pair
    '{5'd3,  1'b1, 3'd2,      5'd2,  5'd24, 5'd0, 5'd0},
    '{5'd30, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd30, 1'b1, 3'd4,      5'd2,  5'd21, 5'd2, 5'd21},
    '{5'd24, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd20, 1'b0, 3'd2,      5'd25, 5'd19, 5'd0, 5'd0},
    '{5'd29, 1'b0, 3'd0,      5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd9,  1'b1, 3'd2,      5'd3,  5'd5,  5'd0, 5'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [4:0] letter, [7:5] zero
  logic        s_axis_tlast;   // last_letter
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [4:0] cipher_letter, [7:5] zero
  logic        m_axis_tlast;   // end_of_run

  rows_t          key_square;
  letter_t        held_ltr;
  logic           held_ok;
  cipher_word_t   cipher_queue[$];
  int             mismatches;
  int             quiet_cycles;
  bit             sink_hold_req;
  bit             sink_holding;

  playfair_digraph_encryptor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor

  // last match in row-major order wins; absent letters sit at row 0, column 0
  function automatic void find_letter(input letter_t v, output int r, output int c);
    r = 0;
    c = 0;
    for (int i = 0; i < NUM_ROWS; i++)
      for (int k = 0; k < NUM_COLS; k++)
        if (key_square[i][k] == v) begin
          r = i;
          c = k;
        end
  endfunction

  function automatic void push_digraph(input letter_t a, input letter_t b, input logic eor);
    int r1, c1, r2, c2;
    letter_t e1, e2;
    find_letter(a, r1, c1);
    find_letter(b, r2, c2);
    if (r1 == r2) begin
      e1 = key_square[r1][(c1 + 1) % NUM_COLS];
      e2 = key_square[r2][(c2 + 1) % NUM_COLS];
    end else if (c1 == c2) begin
      e1 = key_square[(r1 + 1) % NUM_ROWS][c1];
      e2 = key_square[(r2 + 1) % NUM_ROWS][c2];
    end else begin
      e1 = key_square[r1][c2];
      e2 = key_square[r2][c1];
    end
    cipher_queue.push_back(cipher_word_t'{e1, 1'b0});
    cipher_queue.push_back(cipher_word_t'{e2, eor});
  endfunction

  // returns the number of cipher words the letter gives rise to
  function automatic int predict_letter(input letter_t raw, input logic last);
    letter_t a;
    a = (raw == LETTER_J) ? LETTER_I : raw;
    if (!held_ok) begin
      if (last) begin
        push_digraph(a, LETTER_X, 1'b1);
        return 2;
      end
      held_ltr = a;
      held_ok  = 1'b1;
      return 0;
    end
    if (held_ltr != a) begin
      push_digraph(held_ltr, a, 1'b1);
      held_ok  = 1'b0;
      held_ltr = '0;
      return 2;
    end
    // doubled letter: first one goes out with X, second waits
    push_digraph(held_ltr, LETTER_X, !last);
    if (last) begin
      push_digraph(a, LETTER_X, 1'b1);
      held_ok  = 1'b0;
      held_ltr = '0;
      return 4;
    end
    return 2;
  endfunction

  // ---------------------------------------------------------------- APB

  task automatic apb_write(input int idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < NUM_ROWS) key_square[idx] = val[24:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input int idx, output logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(4 * idx);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_square(input rows_t sq);
    for (int i = REG_ROW_0; i <= REG_ROW_4; i++) apb_write(i, {7'd0, sq[i]});
  endtask

  task automatic check_square();
    logic [31:0] got;
    for (int i = REG_ROW_0; i <= REG_ROW_4; i++) begin
      apb_read(i, got);
      if (got != {7'd0, key_square[i]})
        report_mismatch($sformatf("table row %0d readback", i), got, key_square[i]);
    end
  endtask

  // the 26 letters less one, shuffled into the square
  task automatic load_shuffled(input letter_t skip);
    letter_t pool[$];
    letter_t t;
    rows_t   sq;
    int      j;
    for (int n = 0; n < 26; n++)
      if (letter_t'(n) != skip) pool.push_back(letter_t'(n));
    for (int n = pool.size() - 1; n > 0; n--) begin
      j       = $urandom_range(0, n);
      t       = pool[n];
      pool[n] = pool[j];
      pool[j] = t;
    end
    for (int n = 0; n < NUM_ROWS * NUM_COLS; n++) sq[n / NUM_COLS][n % NUM_COLS] = pool[n];
    write_square(sq);
  endtask

  // ---------------------------------------------------------------- stream

  task automatic send_letter(input letter_t ltr, input logic last, output int made);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ltr};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    made = predict_letter(ltr, last);
  endtask

  task automatic sender_pause();
    int pick, span;
    pick = $urandom_range(0, 99);
    if (pick < 55)      span = 0;
    else if (pick < 85) span = $urandom_range(1, 2);
    else if (pick < 95) span = $urandom_range(3, 6);
    else                span = $urandom_range(10, 40);
    repeat (span) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // a waiting letter gives no word, so allow for one still in the pipe
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : sink_pacing
    int   pick, span;
    logic lvl;
    m_axis_tready = 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_holding  = 1'b1;
        lvl  = 1'b0;
        span = LONG_HOLD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          lvl  = 1'b1;
          span = $urandom_range(1, 8);
        end else if (pick < 85) begin
          lvl  = 1'b0;
          span = $urandom_range(1, 3);
        end else if (pick < 95) begin
          lvl  = 1'b1;
          span = $urandom_range(20, 40);
        end else begin
          lvl  = 1'b0;
          span = $urandom_range(8, 25);
        end
      end
      repeat (span) begin
        @(negedge clk_i);
        m_axis_tready <= lvl;
      end
      sink_holding = 1'b0;
    end
  end

  always @(posedge clk_i) begin : cipher_check
    cipher_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_queue.size() == 0) begin
        report_mismatch("word with nothing expected", m_axis_tdata[4:0], 0);
      end else begin
        want = cipher_queue.pop_front();
        if (m_axis_tdata[4:0] != want.ltr)
          report_mismatch("cipher_letter", m_axis_tdata[4:0], want.ltr);
        if (m_axis_tlast != want.eor)
          report_mismatch("end_of_run", m_axis_tlast, want.eor);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    rows_t   sq;
    letter_t typed[4];
    letter_t ltr, prev;
    int      made, sent, msg_len, pick, hurry_left;
    bit      no_gaps;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    mismatches    = 0;
    sink_hold_req = 1'b0;
    sink_holding  = 1'b0;
    held_ltr      = '0;
    held_ok       = 1'b0;
    for (int n = 0; n < NUM_ROWS * NUM_COLS; n++)
      key_square[n / NUM_COLS][n % NUM_COLS] = letter_t'((n < LETTER_J) ? n : n + 1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_square();

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_letter(DIRECTED[i].ltr, DIRECTED[i].last, made);
      if (DIRECTED[i].cnt != UNCHECKED) begin
        typed = '{DIRECTED[i].e0, DIRECTED[i].e1, DIRECTED[i].e2, DIRECTED[i].e3};
        repeat (made) void'(cipher_queue.pop_back());
        for (int k = 0; k < DIRECTED[i].cnt; k++)
          cipher_queue.push_back(cipher_word_t'{typed[k], logic'(k == DIRECTED[i].cnt - 1)});
      end
      sender_pause();
    end
    wait_for_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0, 4: load_shuffled(LETTER_J);
        1: begin
          sq = '0;
          write_square(sq);
        end
        2: begin
          sq = '1;
          write_square(sq);
        end
        3: begin
          for (int i = REG_ROW_0; i <= REG_ROW_4; i++) sq[i] = row_t'($urandom());
          write_square(sq);
        end
        default: load_shuffled(letter_t'($urandom_range(0, 25)));
      endcase
      // beyond the last row: must leave the square alone
      apb_write(NUM_ROWS, $urandom());
      check_square();

      no_gaps    = (phase == 4);
      hurry_left = 0;
      if (phase == 0) begin
        // stall the sink and keep offering words until the input backs up
        sink_hold_req = 1'b1;
        wait (sink_holding);
        hurry_left = 24;
      end

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        msg_len = $urandom_range(1, 10);
        prev    = letter_t'($urandom_range(0, 25));
        for (int k = 0; k < msg_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 20)      ltr = prev;
          else if (pick < 28) ltr = LETTER_X;
          else if (pick < 34) ltr = LETTER_J;
          else if (pick < 40) ltr = letter_t'($urandom_range(26, 31));
          else                ltr = letter_t'($urandom_range(0, 25));
          send_letter(ltr, k == msg_len - 1, made);
          prev = ltr;
          sent++;
          if (hurry_left > 0)
            hurry_left--;
          else if (!no_gaps)
            sender_pause();
          if (phase == 2 && sent == 20) wait_for_results();
        end
      end
      wait_for_results();
    end

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
